FILE: hw/rtl/assert_macros.svh
// Assertion macros used by kruskal_mst_weight.sv.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/kmst_pkg.sv
// Package for the spanning forest weight block: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package kmst_pkg;
  localparam int VtxBits = 8;
  localparam int WgtBits = 16;
  localparam int SumBits = 26;
  localparam int CfgBits = 9;

  typedef struct packed {
    logic [VtxBits-1:0] from_vertex;
    logic [VtxBits-1:0] to_vertex;
    logic [WgtBits-1:0] weight;
    logic               last_edge;
  } in_item_t;

  typedef struct packed {
    logic [SumBits-1:0] tree_weight;
    logic [SumBits-1:0] total_weight;
    logic [SumBits-1:0] saved_weight;
    logic               dropped_flag;
  } out_item_t;
endpackage

FILE: hw/rtl/kruskal_mst_weight.sv
// Top level of the spanning forest weight block.
// Depends on kmst_pkg, kmst_ram and assert_macros.svh.
//
// Edge transactions arrive on in_valid/in_stall/in_data; one result transaction
// leaves on out_valid/out_stall/out_data after each edge marked last_edge.
// cfg_we/cfg_wdata set vertex_count; the user must write them only while the
// block idles; the block does not enforce this. Edges load at one per cycle
// into the edge memory while loading. After the last edge, no more are taken and
// the block runs three phases:
//   a clearing pass that makes each vertex of the parent memory its own root;
//   an insertion sort of the stored edges into ascending order;
//   the union-find pass, which follows parent links and joins differing roots.
// The result sits in an output register until taken; the next graph's edges
// are accepted once the result transaction completes. A stalled result holds.
// Reset returns the block to loading with an empty edge memory, vertex_count
// 256, and starts no clearing pass (the parent memory is cleared per graph).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kruskal_mst_weight #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kmst_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kmst_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [kmst_pkg::CfgBits-1:0] cfg_wdata
);
  import kmst_pkg::*;

  localparam int EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ED  = (MAX_EDGES > 1) ? MAX_EDGES : 2;
  localparam int CW  = $clog2(MAX_EDGES + 1) + 1;
  localparam int VA  = $clog2(MAX_VERTICES);
  localparam int KW  = WgtBits + 2 * VtxBits;

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_SRD, S_SKEY, S_SCMP, S_SPUT,
    S_URD, S_UEDGE, S_FWAIT, S_FSTEP, S_ULINK, S_OUT
  } state_t;

  state_t state_r;
  logic [CfgBits-1:0] vcnt_r;
  logic [CW-1:0] cnt_r;
  logic [SumBits:0] sum_r, tree_r;
  logic drop_r;
  logic [CW-1:0] i_r, j_r;
  logic [KW-1:0] key_r, edge_r;
  logic [VA-1:0] clr_r, x_r, ru_r;
  logic second_r;
  out_item_t out_r;
  logic out_valid_r;

  logic e_we;
  logic [EA-1:0] e_wa, e_ra;
  logic [KW-1:0] e_wd, e_rd;
  logic p_we;
  logic [VA-1:0] p_wa, p_ra, p_rd, p_root;

  kmst_ram #(.WIDTH(KW), .DEPTH(ED)) u_edge (
    .clk, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd)
  );
  kmst_ram #(.WIDTH(VA), .DEPTH(MAX_VERTICES)) u_par (
    .clk, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_root), .rd_addr(p_ra), .rd_data(p_rd)
  );

  logic accept, bad, full;
  assign in_stall = (state_r != S_LOAD);
  assign accept = in_valid && !in_stall;
  assign full = (cnt_r >= CW'(MAX_EDGES));
  assign bad = full || ({1'b0, in_data.from_vertex} >= vcnt_r) ||
               ({1'b0, in_data.to_vertex} >= vcnt_r) ||
               (32'(in_data.from_vertex) >= MAX_VERTICES) ||
               (32'(in_data.to_vertex) >= MAX_VERTICES);

  logic [VA-1:0] to_v;
  assign to_v   = VA'(edge_r[VtxBits-1:0]);

  always_comb begin
    e_we = 1'b0;
    e_wa = cnt_r[EA-1:0];
    e_wd = {in_data.weight, in_data.from_vertex, in_data.to_vertex};
    e_ra = i_r[EA-1:0];
    p_we = 1'b0;
    p_wa = clr_r;
    p_root = clr_r;
    p_ra = x_r;
    case (state_r)
      S_LOAD: e_we = accept && !bad;
      S_SRD:  e_ra = i_r[EA-1:0];
      S_SKEY, S_SCMP: e_ra = EA'(j_r - CW'(1));
      S_SPUT: begin
        e_we = 1'b1;
        e_wa = j_r[EA-1:0];
        e_wd = (j_r != '0 && e_rd > key_r) ? e_rd : key_r;
      end
      S_CLR: p_we = 1'b1;
      S_ULINK: begin
        p_we = 1'b1;
        p_wa = ru_r;
        p_root = x_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      vcnt_r <= CfgBits'(256);
      cnt_r <= '0;
      sum_r <= '0;
      drop_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) vcnt_r <= cfg_wdata;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (bad) begin
              drop_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + CW'(1);
              sum_r <= sum_r + (SumBits+1)'(in_data.weight);
            end
            if (in_data.last_edge) begin
              clr_r <= '0;
              state_r <= S_CLR;
            end
          end
        end
        S_CLR: begin
          clr_r <= clr_r + VA'(1);
          if (32'(clr_r) == MAX_VERTICES - 1) begin
            i_r <= CW'(1);
            state_r <= S_SRD;
          end
        end
        S_SRD: begin
          if (i_r >= cnt_r) begin
            i_r <= '0;
            tree_r <= '0;
            state_r <= S_URD;
          end else begin
            j_r <= i_r;
            state_r <= S_SKEY;
          end
        end
        S_SKEY: begin
          key_r <= e_rd;
          state_r <= S_SCMP;
        end
        S_SCMP: state_r <= S_SPUT;
        S_SPUT: begin
          if (j_r != '0 && e_rd > key_r) begin
            j_r <= j_r - CW'(1);
            state_r <= S_SCMP;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_SRD;
          end
        end
        S_URD: begin
          if (i_r >= cnt_r) begin
            out_r.tree_weight <= tree_r[SumBits-1:0];
            out_r.total_weight <= sum_r[SumBits-1:0];
            out_r.saved_weight <= SumBits'(sum_r - tree_r);
            out_r.dropped_flag <= drop_r;
            out_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_UEDGE;
          end
        end
        S_UEDGE: begin
          edge_r <= e_rd;
          x_r <= VA'(e_rd[2*VtxBits-1:VtxBits]);
          second_r <= 1'b0;
          state_r <= S_FWAIT;
        end
        S_FWAIT: state_r <= S_FSTEP;
        S_FSTEP: begin
          if (p_rd != x_r) begin
            x_r <= p_rd;
            state_r <= S_FWAIT;
          end else if (!second_r) begin
            ru_r <= x_r;
            x_r <= to_v;
            second_r <= 1'b1;
            state_r <= S_FWAIT;
          end else if (ru_r != x_r) begin
            tree_r <= tree_r + (SumBits+1)'(edge_r[KW-1:2*VtxBits]);
            state_r <= S_ULINK;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_URD;
          end
        end
        S_ULINK: begin
          i_r <= i_r + CW'(1);
          state_r <= S_URD;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            cnt_r <= '0;
            sum_r <= '0;
            drop_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `ASSERT_IMPL(a_out_in_out_state, clk, rst_n, out_valid_r |-> (state_r == S_OUT))
  `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CW'(MAX_EDGES))
  `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid_r && out_stall) |=> $stable(out_r))
endmodule

FILE: hw/rtl/kmst_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
